FILE: sv/class_keyed_idle_connection_pool_unit_macros.svh
// Assertion helpers shared by the pool's modules.
`ifndef CLASS_KEYED_IDLE_CONNECTION_POOL_UNIT_MACROS_SVH
`define CLASS_KEYED_IDLE_CONNECTION_POOL_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CIKP_ASSERT_IMPLY(name, clk, rst, a, c) \
   name: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("cikp: check failed");

// Next-cycle implication, disabled while reset is high.
`define CIKP_ASSERT_NEXT(name, clk, rst, a, c) \
   name: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("cikp: check failed");

`endif

FILE: sv/cikp_pkg.sv
package cikp_pkg;

   // operation codes
   localparam logic [2:0] OP_ATTACH     = 3'd0;
   localparam logic [2:0] OP_DETACH     = 3'd1;
   localparam logic [2:0] OP_TAKE_CLASS = 3'd2;
   localparam logic [2:0] OP_TAKE_ANY   = 3'd3;
   localparam logic [2:0] OP_PUT_IDLE   = 3'd4;
   localparam logic [2:0] OP_DRAIN      = 3'd5;

   // result status codes
   localparam logic [2:0] STS_OK       = 3'd0;
   localparam logic [2:0] STS_FULL     = 3'd1;
   localparam logic [2:0] STS_ALREADY  = 3'd2;
   localparam logic [2:0] STS_NOSLOT   = 3'd3;
   localparam logic [2:0] STS_INVALID  = 3'd4;
   localparam logic [2:0] STS_SHUTDOWN = 3'd5;
   localparam logic [2:0] STS_EMPTY    = 3'd6;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_FRD,
      S_FLAT,
      S_DEC,
      S_SRD,
      S_SCHK,
      S_SEND,
      S_ATT,
      S_POPRD,
      S_POPWR,
      S_PUSH,
      S_UNL,
      S_WRD,
      S_WCHK,
      S_DCLR,
      S_DONE
   } state_type;

   // flow table read address source
   typedef enum logic [1:0] {
      FRD_FID,
      FRD_TOP,
      FRD_CUR
   } frd_sel_type;

   typedef struct packed {
      logic        clr_step;
      logic        load_req;
      frd_sel_type frd_sel;
      logic        f_latch;
      logic        scan_init;
      logic        scan_chk;
      logic        scan_inc;
      logic        claim;
      logic        attach_wr;
      logic        pop_wr;
      logic        push_wr;
      logic        unl_top;
      logic        walk_init;
      logic        walk_fix;
      logic        walk_step;
      logic        det_wr;
      logic        set_drain;
      logic        set_st;
      logic [2:0]  st;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic       clr_last;
      logic [2:0] op;
      logic       fok;
      logic       f_att;
      logic       f_idle;
      logic       f_cls_zero;
      logic       key_zero;
      logic       drain;
      logic       may_create;
      logic       hit;
      logic       last_slot;
      logic       found;
      logic       spare_have;
      logic       crec_hv;
      logic       top_is_f;
      logic       w_nv;
      logic       w_nxt_is_f;
      logic       step_last;
      logic       rsp_busy;
   } sts_type;

endpackage

FILE: sv/cikp_ram.sv
module cikp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/cikp_ctrl.sv
`include "class_keyed_idle_connection_pool_unit_macros.svh"

module cikp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cikp_pkg::sts_type sts,
   output cikp_pkg::cmd_type cmd
);

   cikp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cikp_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      cmd.frd_sel = cikp_pkg::FRD_FID;
      cmd.st   = cikp_pkg::STS_OK;
      state_in = state_ff;
      unique case (state_ff)
         cikp_pkg::S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = cikp_pkg::S_IDLE;
         end
         cikp_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = cikp_pkg::S_FRD;
            end
         end
         cikp_pkg::S_FRD: begin
            state_in = cikp_pkg::S_FLAT;
         end
         cikp_pkg::S_FLAT: begin
            cmd.f_latch = 1'b1;
            state_in = cikp_pkg::S_DEC;
         end
         cikp_pkg::S_DEC: begin
            state_in = cikp_pkg::S_DONE;
            case (sts.op)
               cikp_pkg::OP_ATTACH: begin
                  if (sts.key_zero || !sts.may_create) begin
                     cmd.set_st = 1'b1; cmd.st = cikp_pkg::STS_FULL;
                  end else if (!sts.fok) begin
                     cmd.set_st = 1'b1; cmd.st = cikp_pkg::STS_INVALID;
                  end else if (sts.f_att) begin
                     cmd.set_st = 1'b1; cmd.st = cikp_pkg::STS_ALREADY;
                  end else begin
                     cmd.scan_init = 1'b1; state_in = cikp_pkg::S_SRD;
                  end
               end
               cikp_pkg::OP_DETACH: begin
                  if (!sts.fok || !sts.f_att) begin
                     cmd.set_st = 1'b1; cmd.st = cikp_pkg::STS_INVALID;
                  end else begin
                     cmd.scan_init = 1'b1; state_in = cikp_pkg::S_SRD;
                  end
               end
               cikp_pkg::OP_TAKE_CLASS: begin
                  if (sts.drain) begin
                     cmd.set_st = 1'b1; cmd.st = cikp_pkg::STS_SHUTDOWN;
                  end else begin
                     cmd.scan_init = 1'b1; state_in = cikp_pkg::S_SRD;
                  end
               end
               cikp_pkg::OP_TAKE_ANY: begin
                  cmd.scan_init = 1'b1; state_in = cikp_pkg::S_SRD;
               end
               cikp_pkg::OP_PUT_IDLE: begin
                  if (!sts.fok || !sts.f_att || sts.f_cls_zero || sts.f_idle) begin
                     cmd.set_st = 1'b1; cmd.st = cikp_pkg::STS_INVALID;
                  end else if (sts.drain) begin
                     cmd.set_st = 1'b1; cmd.st = cikp_pkg::STS_SHUTDOWN;
                  end else begin
                     cmd.scan_init = 1'b1; state_in = cikp_pkg::S_SRD;
                  end
               end
               cikp_pkg::OP_DRAIN: begin
                  cmd.set_drain = 1'b1;
               end
               default: begin
                  cmd.set_st = 1'b1; cmd.st = cikp_pkg::STS_INVALID;
               end
            endcase
         end
         cikp_pkg::S_SRD: begin
            state_in = cikp_pkg::S_SCHK;
         end
         cikp_pkg::S_SCHK: begin
            cmd.scan_chk = 1'b1;
            if (sts.hit || sts.last_slot) begin
               state_in = cikp_pkg::S_SEND;
            end else begin
               cmd.scan_inc = 1'b1;
               state_in = cikp_pkg::S_SRD;
            end
         end
         cikp_pkg::S_SEND: begin
            state_in = cikp_pkg::S_DONE;
            case (sts.op) inside
               cikp_pkg::OP_ATTACH, cikp_pkg::OP_PUT_IDLE: begin
                  if (sts.found || sts.spare_have) begin
                     cmd.claim = !sts.found;
                     state_in = (sts.op == cikp_pkg::OP_ATTACH) ?
                                cikp_pkg::S_ATT : cikp_pkg::S_PUSH;
                  end else begin
                     cmd.set_st = 1'b1; cmd.st = cikp_pkg::STS_NOSLOT;
                  end
               end
               cikp_pkg::OP_DETACH: begin
                  state_in = (sts.found && sts.f_idle) ? cikp_pkg::S_UNL : cikp_pkg::S_DCLR;
               end
               default: begin
                  if (sts.found && sts.crec_hv) begin
                     state_in = cikp_pkg::S_POPRD;
                  end else begin
                     cmd.set_st = 1'b1; cmd.st = cikp_pkg::STS_EMPTY;
                  end
               end
            endcase
         end
         cikp_pkg::S_ATT: begin
            cmd.attach_wr = 1'b1;
            state_in = cikp_pkg::S_DONE;
         end
         cikp_pkg::S_POPRD: begin
            cmd.frd_sel = cikp_pkg::FRD_TOP;
            state_in = cikp_pkg::S_POPWR;
         end
         cikp_pkg::S_POPWR: begin
            cmd.pop_wr = 1'b1;
            state_in = cikp_pkg::S_DONE;
         end
         cikp_pkg::S_PUSH: begin
            cmd.push_wr = 1'b1;
            state_in = cikp_pkg::S_DONE;
         end
         cikp_pkg::S_UNL: begin
            if (!sts.crec_hv) begin
               state_in = cikp_pkg::S_DCLR;
            end else if (sts.top_is_f) begin
               cmd.unl_top = 1'b1;
               state_in = cikp_pkg::S_DCLR;
            end else begin
               cmd.walk_init = 1'b1;
               state_in = cikp_pkg::S_WRD;
            end
         end
         cikp_pkg::S_WRD: begin
            cmd.frd_sel = cikp_pkg::FRD_CUR;
            state_in = cikp_pkg::S_WCHK;
         end
         cikp_pkg::S_WCHK: begin
            cmd.frd_sel = cikp_pkg::FRD_CUR;
            if (!sts.w_nv) begin
               state_in = cikp_pkg::S_DCLR;
            end else if (sts.w_nxt_is_f) begin
               cmd.walk_fix = 1'b1;
               state_in = cikp_pkg::S_DCLR;
            end else if (sts.step_last) begin
               state_in = cikp_pkg::S_DCLR;
            end else begin
               cmd.walk_step = 1'b1;
               state_in = cikp_pkg::S_WRD;
            end
         end
         cikp_pkg::S_DCLR: begin
            cmd.det_wr = 1'b1;
            state_in = cikp_pkg::S_DONE;
         end
         cikp_pkg::S_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in = cikp_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cikp_pkg::S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != cikp_pkg::S_IDLE);

   // a chain check always follows its chain read
   `CIKP_ASSERT_IMPLY(a_walk_order, clock, reset, state_ff == cikp_pkg::S_WCHK, $past(state_ff) == cikp_pkg::S_WRD)

endmodule

FILE: sv/cikp_dp.sv
`include "class_keyed_idle_connection_pool_unit_macros.svh"

module cikp_dp #(
   parameter int NUM_CLASSES = 16,
   parameter int NUM_FLOWS   = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [2:0]        req_op,
   input  logic [7:0]        req_flow_id,
   input  logic [15:0]       req_class_key,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic [2:0]        rsp_status,
   output logic [7:0]        rsp_result_flow,
   output logic              rsp_result_flow_valid,
   output logic              rsp_can_create,
   output logic [8:0]        rsp_live_connections,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   input  cikp_pkg::cmd_type cmd,
   output cikp_pkg::sts_type sts
);

   localparam int FIW  = $clog2(NUM_FLOWS);
   localparam int CIW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int CLRN = (NUM_FLOWS > NUM_CLASSES) ? NUM_FLOWS : NUM_CLASSES;
   localparam int CLW  = $clog2(CLRN);
   localparam int FRW  = FIW + 19;  // att, idle, class, next valid, next
   localparam int CRW  = FIW + 17;  // key, head valid, head
   localparam logic CSR_IDX_LIMIT = 1'b0;

   logic [2:0]     op_ff;
   logic [FIW-1:0] fid_ff;
   logic           fok_ff;
   logic [15:0]    key_ff;
   logic [8:0]     limit_ff;
   logic [8:0]     count_ff, count_in;
   logic           drain_ff;
   logic [CLW-1:0] clr_ff;
   logic [FRW-1:0] frec_ff;
   logic [CIW-1:0] sidx_ff, spare_ff, slot_ff;
   logic           found_ff, spare_have_ff;
   logic [CRW-1:0] crec_ff;
   logic [FIW-1:0] cur_ff, steps_ff, rflow_ff;
   logic [2:0]     status_ff;
   logic           taken_ff;
   logic           rsp_valid_ff;
   logic [2:0]     rsp_status_ff;
   logic [7:0]     rsp_flow_ff;
   logic           rsp_taken_ff, rsp_can_ff;
   logic [8:0]     rsp_live_ff;

   logic           f_we, c_we;
   logic [FIW-1:0] f_waddr, f_raddr;
   logic [CIW-1:0] c_waddr;
   logic [FRW-1:0] f_wdata, f_rdata;
   logic [CRW-1:0] c_wdata, c_rdata;

   logic           rd_att, rd_idle, rd_nv, f_att, f_idle, f_nv, c_hv, cr_hv;
   logic [15:0]    rd_cls, f_cls, c_key, cr_key, skey;
   logic [FIW-1:0] rd_nxt, f_nxt, c_head;
   logic           may_create, hit;

   assign {rd_att, rd_idle, rd_cls, rd_nv, rd_nxt} = f_rdata;
   assign {f_att, f_idle, f_cls, f_nv, f_nxt}      = frec_ff;
   assign {c_key, c_hv, c_head}                    = crec_ff;
   assign cr_key = c_rdata[CRW-1:FIW+1];
   assign cr_hv  = c_rdata[FIW];

   assign skey = (op_ff == cikp_pkg::OP_DETACH || op_ff == cikp_pkg::OP_PUT_IDLE) ?
                 f_cls : key_ff;
   assign hit  = (op_ff == cikp_pkg::OP_TAKE_ANY) ? cr_hv :
                 ((skey != 16'h0) && (cr_key == skey));
   assign may_create = !drain_ff && (count_ff < limit_ff);

   cikp_ram #(.WIDTH(FRW), .DEPTH(NUM_FLOWS)) u_flow_ram (
      .clock   (clock),
      .wr_en   (f_we),
      .wr_addr (f_waddr),
      .wr_data (f_wdata),
      .rd_addr (f_raddr),
      .rd_data (f_rdata)
   );

   cikp_ram #(.WIDTH(CRW), .DEPTH(NUM_CLASSES)) u_class_ram (
      .clock   (clock),
      .wr_en   (c_we),
      .wr_addr (c_waddr),
      .wr_data (c_wdata),
      .rd_addr (sidx_ff),
      .rd_data (c_rdata)
   );

   always_comb begin
      case (cmd.frd_sel)
         cikp_pkg::FRD_TOP: f_raddr = c_head;
         cikp_pkg::FRD_CUR: f_raddr = cur_ff;
         default:           f_raddr = fid_ff;
      endcase
   end

   // flow table write port
   always_comb begin
      f_we    = 1'b0;
      f_waddr = fid_ff;
      f_wdata = '0;
      if (cmd.clr_step) begin
         f_we    = ({1'b0, clr_ff} < (CLW+1)'(NUM_FLOWS));
         f_waddr = clr_ff[FIW-1:0];
      end else if (cmd.attach_wr) begin
         f_we    = 1'b1;
         f_wdata = {1'b1, 1'b0, key_ff, 1'b0, {FIW{1'b0}}};
      end else if (cmd.pop_wr) begin
         f_we    = 1'b1;
         f_waddr = c_head;
         f_wdata = {rd_att, 1'b0, rd_cls, 1'b0, {FIW{1'b0}}};
      end else if (cmd.push_wr) begin
         f_we    = 1'b1;
         f_wdata = {f_att, 1'b1, f_cls, c_hv, c_head};
      end else if (cmd.walk_fix) begin
         f_we    = 1'b1;
         f_waddr = cur_ff;
         f_wdata = {rd_att, rd_idle, rd_cls, f_nv, f_nxt};
      end else if (cmd.det_wr) begin
         f_we    = 1'b1;
         f_wdata = {1'b0, 1'b0, f_cls, 1'b0, {FIW{1'b0}}};
      end
   end

   // class table write port
   always_comb begin
      c_we    = 1'b0;
      c_waddr = slot_ff;
      c_wdata = '0;
      if (cmd.clr_step) begin
         c_we    = ({1'b0, clr_ff} < (CLW+1)'(NUM_CLASSES));
         c_waddr = clr_ff[CIW-1:0];
      end else if (cmd.claim) begin
         c_we    = 1'b1;
         c_waddr = spare_ff;
         c_wdata = {skey, 1'b0, {FIW{1'b0}}};
      end else if (cmd.pop_wr) begin
         c_we    = 1'b1;
         c_wdata = {c_key, rd_nv, rd_nxt};
      end else if (cmd.push_wr) begin
         c_we    = 1'b1;
         c_wdata = {c_key, 1'b1, fid_ff};
      end else if (cmd.unl_top) begin
         c_we    = 1'b1;
         c_wdata = {c_key, f_nv, f_nxt};
      end else if (cmd.det_wr) begin
         // slot freed once its stack is empty
         c_we    = found_ff && !c_hv;
         c_wdata = {16'h0, 1'b0, c_head};
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.attach_wr) begin
         count_in = count_ff + 9'd1;
      end else if (cmd.det_wr && (count_ff != 9'd0)) begin
         count_in = count_ff - 9'd1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= 9'd256;
         count_ff     <= '0;
         drain_ff     <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == CSR_IDX_LIMIT)) begin
            limit_ff <= csr_pwdata[8:0];
         end
         count_ff <= count_in;
         if (cmd.set_drain) drain_ff <= 1'b1;
         if (cmd.clr_step) clr_ff <= clr_ff + CLW'(1);
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff     <= req_op;
         fid_ff    <= FIW'(req_flow_id);
         fok_ff    <= (17'(req_flow_id) < 17'(NUM_FLOWS));
         key_ff    <= req_class_key;
         status_ff <= cikp_pkg::STS_OK;
         taken_ff  <= 1'b0;
         rflow_ff  <= '0;
      end
      if (cmd.set_st) status_ff <= cmd.st;
      if (cmd.f_latch) frec_ff <= f_rdata;
      if (cmd.scan_init) begin
         sidx_ff       <= '0;
         found_ff      <= 1'b0;
         spare_have_ff <= 1'b0;
      end
      if (cmd.scan_inc) sidx_ff <= sidx_ff + CIW'(1);
      if (cmd.scan_chk) begin
         if (hit) begin
            found_ff <= 1'b1;
            slot_ff  <= sidx_ff;
            crec_ff  <= c_rdata;
         end
         if (!spare_have_ff && (cr_key == 16'h0)) begin
            spare_have_ff <= 1'b1;
            spare_ff      <= sidx_ff;
         end
      end
      if (cmd.claim) begin
         slot_ff <= spare_ff;
         crec_ff <= {skey, 1'b0, {FIW{1'b0}}};
      end
      if (cmd.unl_top) crec_ff <= {c_key, f_nv, f_nxt};
      if (cmd.pop_wr) begin
         taken_ff <= 1'b1;
         rflow_ff <= c_head;
      end
      if (cmd.walk_init) begin
         cur_ff   <= c_head;
         steps_ff <= '0;
      end
      if (cmd.walk_step) begin
         cur_ff   <= rd_nxt;
         steps_ff <= steps_ff + FIW'(1);
      end
      if (cmd.out_load) begin
         rsp_status_ff <= status_ff;
         rsp_flow_ff   <= 8'(rflow_ff);
         rsp_taken_ff  <= taken_ff;
         rsp_can_ff    <= may_create;
         rsp_live_ff   <= count_ff;
      end
   end

   always_comb begin
      sts            = '0;
      sts.clr_last   = (clr_ff == CLW'(CLRN - 1));
      sts.op         = op_ff;
      sts.fok        = fok_ff;
      sts.f_att      = f_att;
      sts.f_idle     = f_idle;
      sts.f_cls_zero = (f_cls == 16'h0);
      sts.key_zero   = (key_ff == 16'h0);
      sts.drain      = drain_ff;
      sts.may_create = may_create;
      sts.hit        = hit;
      sts.last_slot  = (sidx_ff == CIW'(NUM_CLASSES - 1));
      sts.found      = found_ff;
      sts.spare_have = spare_have_ff;
      sts.crec_hv    = c_hv;
      sts.top_is_f   = (c_head == fid_ff);
      sts.w_nv       = rd_nv;
      sts.w_nxt_is_f = (rd_nxt == fid_ff);
      sts.step_last  = (steps_ff == FIW'(NUM_FLOWS - 1));
      sts.rsp_busy   = rsp_valid_ff && rsp_stall;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_result_flow       = rsp_flow_ff;
   assign rsp_result_flow_valid = rsp_taken_ff;
   assign rsp_can_create        = rsp_can_ff;
   assign rsp_live_connections  = rsp_live_ff;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_LIMIT) ? 32'(limit_ff) : 32'h0;

   `CIKP_ASSERT_NEXT(a_out_shown, clock, reset, cmd.out_load, rsp_valid_ff)
   `CIKP_ASSERT_IMPLY(a_taken_ok, clock, reset, rsp_valid_ff && rsp_taken_ff, rsp_status_ff == cikp_pkg::STS_OK)
   `CIKP_ASSERT_IMPLY(a_count_cap, clock, reset, 1'b1, count_ff <= 9'd256)

endmodule

FILE: sv/class_keyed_idle_connection_pool_unit.sv
// Channel  | Direction | Handshake         | Word
// req_     | in        | valid / stall     | op, flow_id, class_key
// rsp_     | out       | valid / stall     | status, result_flow, result_flow_valid,
//          |           |                   | can_create, live_connections
// csr_     | in        | APB, pready tied  | connection_limit at byte address 0
//
// One word in flight in the sequencer. A word settled at decode goes straight to the
// result step; otherwise the class slots are scanned in turn (up to NUM_CLASSES), and
// a detach of a buried idle flow also walks the idle chain link by link.
// Both tables are synchronous RAMs with one read and one write port; the scan and
// chain walk each issue one RAM read from a read state followed by a check state.
// After reset a clearing pass over max(NUM_FLOWS, NUM_CLASSES) addresses zeroes both
// tables; req_stall is high throughout. Reset is synchronous, active high.
// A finished word waits in the output register while rsp_stall is high; the next
// request is taken meanwhile and held in its last step until that register frees.
module class_keyed_idle_connection_pool_unit #(
   parameter int NUM_CLASSES = 16,
   parameter int NUM_FLOWS   = 256
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [7:0]  req_flow_id,
   input  logic [15:0] req_class_key,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_result_flow,
   output logic        rsp_result_flow_valid,
   output logic        rsp_can_create,
   output logic [8:0]  rsp_live_connections,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cikp_pkg::cmd_type cmd;
   cikp_pkg::sts_type sts;

   // sequencer: op decode, slot scan, chain walk, result hand-off
   cikp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // tables, counters, limit register and output register
   cikp_dp #(
      .NUM_CLASSES (NUM_CLASSES),
      .NUM_FLOWS   (NUM_FLOWS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .req_op                (req_op),
      .req_flow_id           (req_flow_id),
      .req_class_key         (req_class_key),
      .rsp_stall             (rsp_stall),
      .rsp_valid             (rsp_valid),
      .rsp_status            (rsp_status),
      .rsp_result_flow       (rsp_result_flow),
      .rsp_result_flow_valid (rsp_result_flow_valid),
      .rsp_can_create        (rsp_can_create),
      .rsp_live_connections  (rsp_live_connections),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .cmd                   (cmd),
      .sts                   (sts)
   );

   // no wait states
   assign csr_pready = 1'b1;

endmodule
